@@ src/mac_txt_pkg.sv @@
// ----------------------------------------------------------------------------
// mac_txt_pkg
// Shared widths, constants and types for the MAC address text parser.
// ----------------------------------------------------------------------------
package mac_txt_pkg;

  localparam int CHAR_W   = 8;
  localparam int NIBBLE_W = 4;
  localparam int COUNT_W  = 4;
  localparam int ADDR_W   = 48;

  // digits in a full address, and the saturation point of the digit count
  localparam logic [COUNT_W-1:0] MAC_DIGITS     = 4'd12;
  localparam logic [COUNT_W-1:0] COUNT_SATURATE = 4'd13;

  // offsets from ASCII code to nibble value
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] LOWER_BASE = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] UPPER_BASE = 8'h37;  // 'A' - 10

  // decoded character
  typedef struct packed {
    logic                is_hex;   // 0-9, a-f, A-F
    logic                is_bad;   // letter outside the hex range
    logic [NIBBLE_W-1:0] nibble;   // value when is_hex
  } char_class_t;

endpackage

@@ src/mac_address_text_parser.sv @@
// ----------------------------------------------------------------------------
// mac_address_text_parser
// Parses a printed MAC address, one character per item, into 48 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_*) takes one ASCII character per item in s_tdata, with
//   s_tlast high on the final character of the string. Non-alphanumeric
//   characters are separators and are skipped; a letter outside a-f/A-F
//   marks the string bad; hex digits are shifted in, first digit ending up
//   in bits 47..44. More than twelve digits also rejects the string.
//   Master side (m_*) gives one item per string, on its final character:
//   m_tuser is the ok flag, m_tdata the address (zero when rejected).
// Output: a final character reaches m_* via the input and result registers.
// Throughput: one character per cycle when not stalled (see Stall); all
//   per-character work sits in one pass of decode and shift logic between
//   the input register and the accumulator/result registers.
// Stall: while a result waits on m_tready, non-final characters keep
//   flowing; a final character holds in the input register until the
//   result register frees up (it may free in the same cycle).
// Reset: rst (synchronous) empties both registers and clears the parser
//   state; the state is also cleared after every final character.
// ----------------------------------------------------------------------------
module mac_address_text_parser
  import mac_txt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // slave side
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] character
  input  logic              s_tlast,   // end_of_string
  // master side
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // [47:0] mac_address
  output logic              m_tuser    // [0] address_ok
);

  // input register
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  // parser state
  logic [COUNT_W-1:0] digit_count;
  logic [ADDR_W-1:0]  address_accumulator;
  logic               bad_letter_seen;

  logic [COUNT_W-1:0] digit_count_next;
  logic [ADDR_W-1:0]  address_accumulator_next;
  logic               bad_letter_seen_next;

  // result register
  logic              out_valid;
  logic              out_ok;
  logic [ADDR_W-1:0] out_addr;

  char_class_t char_class;
  logic        advance;
  logic        result_ok;

  mac_txt_classify u_classify (
    .character  (in_char),
    .char_class (char_class)
  );

  // a final character needs a free (or freeing) result register
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_comb begin
    address_accumulator_next = address_accumulator;
    digit_count_next         = digit_count;
    bad_letter_seen_next     = bad_letter_seen | char_class.is_bad;
    if (char_class.is_hex) begin
      if (digit_count < MAC_DIGITS) begin
        address_accumulator_next = {address_accumulator[ADDR_W-NIBBLE_W-1:0],
                                    char_class.nibble};
      end
      if (digit_count < COUNT_SATURATE) begin
        digit_count_next = digit_count + 1'b1;
      end
    end
  end

  assign result_ok = !bad_letter_seen_next && (digit_count_next == MAC_DIGITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      out_valid           <= 1'b0;
      digit_count         <= '0;
      address_accumulator <= '0;
      bad_letter_seen     <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        if (in_last) begin
          digit_count         <= '0;
          address_accumulator <= '0;
          bad_letter_seen     <= 1'b0;
        end else begin
          digit_count         <= digit_count_next;
          address_accumulator <= address_accumulator_next;
          bad_letter_seen     <= bad_letter_seen_next;
        end
      end

      if (advance && in_last) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
    if (advance && in_last) begin
      out_ok   <= result_ok;
      out_addr <= result_ok ? address_accumulator_next : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_addr;
  assign m_tuser  = out_ok;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_SATURATE)
    else $error("digit count beyond saturation");

  a_clear_after_final : assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> digit_count == '0 && !bad_letter_seen
                           && address_accumulator == '0)
    else $error("parser state not cleared after final character");

  a_reject_count : assert property (@(posedge clk) disable iff (rst)
    advance && in_last && digit_count_next != MAC_DIGITS |=> m_tvalid && !m_tuser)
    else $error("string with wrong digit count accepted");

  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("rejected result carries a nonzero address");

endmodule

@@ src/mac_txt_classify.sv @@
// ----------------------------------------------------------------------------
// mac_txt_classify
// Sorts one ASCII character into hex digit, bad letter or separator.
// ----------------------------------------------------------------------------
module mac_txt_classify
  import mac_txt_pkg::*;
(
  input  logic [CHAR_W-1:0] character,
  output char_class_t       char_class
);

  logic                is_digit;
  logic                is_lower_hex;
  logic                is_upper_hex;
  logic                is_lower_other;
  logic                is_upper_other;
  logic [CHAR_W-1:0]   offset;

  assign is_digit       = (character >= 8'h30) && (character <= 8'h39);
  assign is_lower_hex   = (character >= 8'h61) && (character <= 8'h66);
  assign is_upper_hex   = (character >= 8'h41) && (character <= 8'h46);
  assign is_lower_other = (character >= 8'h67) && (character <= 8'h7a);
  assign is_upper_other = (character >= 8'h47) && (character <= 8'h5a);

  always_comb begin
    if (is_lower_hex) begin
      offset = character - LOWER_BASE;
    end else if (is_upper_hex) begin
      offset = character - UPPER_BASE;
    end else begin
      offset = character - DIGIT_BASE;
    end
  end

  assign char_class.is_hex = is_digit | is_lower_hex | is_upper_hex;
  assign char_class.is_bad = is_lower_other | is_upper_other;
  assign char_class.nibble = offset[NIBBLE_W-1:0];

endmodule
